// File: hdl/bba_pkg.sv
// Package for the block bitmap allocator: request/response payload types,
// action codes, sequencer states and word-unit control structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    // Payload field widths
    localparam int ACTION_W = 3;
    localparam int POS_W    = 10;
    localparam int LEN_W    = 11;
    localparam int CNT_W    = 11;

    // Internal bit index width: holds start + length and count + word size
    localparam int IX_W = 12;

    // Map geometry defaults
    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int WORD_W_DEF     = 32;
    localparam int MAX_OFF_W      = 5;

    // Block count after reset
    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = CNT_W'(1024);

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_READ      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_MARK_USED = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_MARK_FREE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SEARCH    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FREE_RUN  = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    position;
        logic [LEN_W-1:0]    length;
        logic                wanted_bit;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] result_position;
        logic             bit_value;
    } t_rsp;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_DONE
    } t_state;

    // Control into the word unit: bit range [lo_off, hi_cnt) of the word
    typedef struct packed {
        logic [MAX_OFF_W-1:0] lo_off;
        logic [MAX_OFF_W:0]   hi_cnt;
        logic                 want;
        logic                 set_val;
    } t_wu_ctl;

    // Status out of the word unit: lowest matching bit inside the range
    typedef struct packed {
        logic                 hit;
        logic [MAX_OFF_W-1:0] hit_off;
    } t_wu_res;

endpackage

`default_nettype wire

// File: hdl/bba_word_unit.sv
// Shared word unit of the block bitmap allocator: range mask, first-match
// search and read-modify-write merge over one map word. Uses bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_word_unit
    import bba_pkg::*;
#(
    parameter int WORD_W = WORD_W_DEF
) (
    input  wire logic [WORD_W-1:0] i_word,
    input  wire t_wu_ctl           i_ctl,
    output t_wu_res                o_res,
    output logic [WORD_W-1:0]      o_wr_word
);

    localparam int OFF_W = $clog2(WORD_W);

    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_mask;
    logic [WORD_W-1:0] range_mask;
    logic [WORD_W-1:0] match;
    logic [OFF_W-1:0]  first;

    // Build the bit range of this word
    always_comb begin
        lo_mask = {WORD_W{1'b1}} << i_ctl.lo_off[OFF_W-1:0];
        if (32'(i_ctl.hi_cnt) >= WORD_W) begin
            hi_mask = {WORD_W{1'b1}};
        end else begin
            hi_mask = ~({WORD_W{1'b1}} << i_ctl.hi_cnt);
        end
        range_mask = lo_mask & hi_mask;
    end

    // Find the lowest bit in range that holds the wanted value
    always_comb begin
        match = (i_ctl.want ? i_word : ~i_word) & range_mask;
        first = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (match[j]) begin
                first = OFF_W'(j);
            end
        end
        o_res.hit     = |match;
        o_res.hit_off = MAX_OFF_W'(first);
    end

    // Merge a mark into the word
    assign o_wr_word = i_ctl.set_val ? (i_word | range_mask) : (i_word & ~range_mask);

endmodule

`default_nettype wire

// File: hdl/block_bitmap_allocator_unit.sv
// Block bitmap allocator: usage map in a word memory, scanned one word per cycle.
// Reset runs a clearing pass over every map word (32 at default) with input stalled.
// Out-of-range or trivial requests skip the scan; a read fetches a single word;
// mark and value search step through each map word touched; free run also
// restarts its scan at each free/used boundary.
// One request at a time; the result register lets the next request in while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module block_bitmap_allocator_unit
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Configuration: block count
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    // Request channel
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_req             i_in_data,
    // Response channel
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_rsp                  o_out_data
);

    localparam int WORD_W = (NUM_BLOCKS >= 64) ? WORD_W_DEF : (1 << $clog2(NUM_BLOCKS)) / 2;
    localparam int OFF_W  = $clog2(WORD_W);
    localparam int DEPTH  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW     = $clog2(DEPTH);

    // Control registers
    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [CNT_W-1:0] r_block_count;
    logic             r_out_valid, n_out_valid;

    // Work registers
    logic [ACTION_W-1:0] r_act, n_act;
    logic [IX_W-1:0]     r_ptr, n_ptr;
    logic [IX_W-1:0]     r_end, n_end;
    logic [IX_W-1:0]     r_cand, n_cand;
    logic [LEN_W-1:0]    r_len, n_len;
    logic                r_want, n_want;
    logic                r_seek_used, n_seek_used;
    t_rsp                r_res, n_res;
    t_rsp                r_out, n_out;

    // Map memory
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] wr_data;

    // Datapath signals
    logic [IX_W-1:0]   lim;
    logic [IX_W-1:0]   pos_x;
    logic [IX_W-1:0]   len_x;
    logic [IX_W-1:0]   run_end;
    logic [IX_W-1:0]   mark_end;
    logic [IX_W-1:0]   word_base;
    logic [IX_W-1:0]   rem;
    logic              last_word;
    logic [OFF_W:0]    hi_cnt;
    logic [IX_W-1:0]   next_base;
    logic [IX_W-1:0]   hit_pos;
    logic [IX_W-1:0]   fit_end;
    logic              out_free;
    t_wu_ctl           wu_ctl;
    t_wu_res           wu_res;
    logic [WORD_W-1:0] wu_wr_word;

    // Effective block count
    assign lim = (32'(r_block_count) > NUM_BLOCKS) ? IX_W'(NUM_BLOCKS)
                                                   : IX_W'(r_block_count);

    // Request operands
    assign pos_x    = IX_W'(i_in_data.position);
    assign len_x    = IX_W'(i_in_data.length);
    assign run_end  = pos_x + len_x;
    assign mark_end = (run_end > lim) ? lim : run_end;

    // Current word window
    assign word_base = r_ptr & ~IX_W'(WORD_W - 1);
    assign rem       = r_end - word_base;
    assign last_word = rem <= IX_W'(WORD_W);
    assign hi_cnt    = last_word ? rem[OFF_W:0] : (OFF_W + 1)'(WORD_W);
    assign next_base = word_base + IX_W'(WORD_W);
    assign hit_pos   = word_base + IX_W'(wu_res.hit_off[OFF_W-1:0]);
    assign fit_end   = hit_pos + IX_W'(r_len);

    assign wu_ctl.lo_off  = MAX_OFF_W'(r_ptr[OFF_W-1:0]);
    assign wu_ctl.hi_cnt  = (MAX_OFF_W + 1)'(hi_cnt);
    assign wu_ctl.want    = r_want;
    assign wu_ctl.set_val = (r_act == ACT_MARK_USED);

    bba_word_unit #(
        .WORD_W (WORD_W)
    ) u_word_unit (
        .i_word    (r_rd_data),
        .i_ctl     (wu_ctl),
        .o_res     (wu_res),
        .o_wr_word (wu_wr_word)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    // Sequencer: next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_act       = r_act;
        n_ptr       = r_ptr;
        n_end       = r_end;
        n_cand      = r_cand;
        n_len       = r_len;
        n_want      = r_want;
        n_seek_used = r_seek_used;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        wr_addr     = AW'(r_ptr >> OFF_W);
        wr_data     = wu_wr_word;

        // Drop the result once the receiver takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we  = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_act       = i_in_data.action;
                    n_len       = i_in_data.length;
                    n_want      = i_in_data.wanted_bit;
                    n_seek_used = 1'b0;
                    n_res       = '0;
                    n_state     = S_DONE;
                    case (i_in_data.action)
                        ACT_READ: begin
                            n_res.found = 1'b1;
                            n_want      = 1'b1;
                            if (pos_x < lim) begin
                                n_ptr   = pos_x;
                                n_end   = pos_x + 1'b1;
                                n_state = S_EVAL;
                            end
                        end
                        ACT_MARK_USED, ACT_MARK_FREE: begin
                            n_res.found = 1'b1;
                            if (pos_x < mark_end) begin
                                n_ptr   = pos_x;
                                n_end   = mark_end;
                                n_state = S_EVAL;
                            end
                        end
                        ACT_SEARCH: begin
                            n_ptr = pos_x + 1'b1;
                            n_end = lim;
                            if (pos_x + 1'b1 < lim) begin
                                n_state = S_EVAL;
                            end
                        end
                        ACT_FREE_RUN: begin
                            if (len_x != '0 && len_x <= lim) begin
                                n_ptr   = '0;
                                n_end   = lim;
                                n_want  = 1'b0;
                                n_state = S_EVAL;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_EVAL: begin
                case (r_act)
                    ACT_READ: begin
                        n_res.bit_value = wu_res.hit;
                        n_state         = S_DONE;
                    end
                    ACT_MARK_USED, ACT_MARK_FREE: begin
                        mem_we = 1'b1;
                        if (last_word) begin
                            n_state = S_DONE;
                        end else begin
                            n_ptr = next_base;
                        end
                    end
                    ACT_SEARCH: begin
                        if (wu_res.hit) begin
                            n_res.found           = 1'b1;
                            n_res.result_position = POS_W'(hit_pos);
                            n_state               = S_DONE;
                        end else if (last_word) begin
                            n_state = S_DONE;
                        end else begin
                            n_ptr = next_base;
                        end
                    end
                    ACT_FREE_RUN: begin
                        if (!r_seek_used) begin
                            // Look for the next free block to start a candidate run
                            if (wu_res.hit) begin
                                if (fit_end > lim) begin
                                    n_state = S_DONE;
                                end else begin
                                    n_cand      = hit_pos;
                                    n_ptr       = hit_pos;
                                    n_end       = fit_end;
                                    n_want      = 1'b1;
                                    n_seek_used = 1'b1;
                                end
                            end else if (last_word) begin
                                n_state = S_DONE;
                            end else begin
                                n_ptr = next_base;
                            end
                        end else begin
                            // Check the candidate run holds no used block
                            if (wu_res.hit) begin
                                n_ptr       = hit_pos + 1'b1;
                                n_end       = lim;
                                n_want      = 1'b0;
                                n_seek_used = 1'b0;
                                if (hit_pos + 1'b1 >= lim) begin
                                    n_state = S_DONE;
                                end
                            end else if (last_word) begin
                                n_res.found           = 1'b1;
                                n_res.result_position = POS_W'(r_cand);
                                n_state               = S_DONE;
                            end else begin
                                n_ptr = next_base;
                            end
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Fetch the word under the next pointer whenever the scan goes on
    assign mem_re  = (n_state == S_EVAL);
    assign rd_addr = AW'(n_ptr >> OFF_W);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_out_valid   <= 1'b0;
            r_block_count <= BLOCK_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_block_count <= i_cfg_wdata;
            end
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        r_act       <= n_act;
        r_ptr       <= n_ptr;
        r_end       <= n_end;
        r_cand      <= n_cand;
        r_len       <= n_len;
        r_want      <= n_want;
        r_seek_used <= n_seek_used;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    // Map memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Map writes come only from the clearing pass or a mark
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR) ||
                   (r_state == S_EVAL && (r_act == ACT_MARK_USED || r_act == ACT_MARK_FREE)))
        else $error("map written outside clear or mark");

    // A scan never runs past its bound or past the block count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_ptr < r_end) && (r_end <= lim))
        else $error("scan pointer outside its window");

    // A finished result waits while the output register is still held
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result left before output register was free");

    // A result is loaded exactly when the sequencer leaves DONE
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not transferred to output register");

    // The clearing pass ends after one sweep of the memory
    a_clear_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_clr == AW'(DEPTH - 1)) |=> (r_state == S_IDLE))
        else $error("clearing pass length wrong");

endmodule

`default_nettype wire

// File: test/block_bitmap_allocator_unit_checker.sv
// Response checker for the block bitmap allocator: tracks its own usage map and
// block count, predicts each response and compares it with the block's output.
// Depends on bba_pkg for the payload types and action codes.
`timescale 1ns / 1ps

module block_bitmap_allocator_unit_checker
    import bba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_stall,
    input  wire t_req             i_in_data,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_stall,
    input  wire t_rsp             i_out_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int MAP_DEPTH    = NUM_BLOCKS_DEF;
    localparam int REPORT_LIMIT = 10;

    logic [MAP_DEPTH-1:0] usage_map;
    logic [CNT_W-1:0]     block_count;
    t_rsp                 expected_rsp_q[$];
    int                   fail_count = 0;
    int                   rsp_index = 0;

    // Block count saturated to the map depth
    function automatic int active_blocks();
        return (block_count > CNT_W'(MAP_DEPTH)) ? MAP_DEPTH : int'(block_count);
    endfunction

    // Write a run of bits, clipped at the active block count
    function automatic void mark_run(int start, int run, logic value);
        int lim;
        lim = active_blocks();
        for (int b = start; b < start + run && b < lim; b++)
            usage_map[b] = value;
    endfunction

    // Apply one request to the tracked map and return the response it gives
    function automatic t_rsp apply_request(t_req r);
        t_rsp rsp;
        int   lim;
        int   free_len;
        lim = active_blocks();
        rsp = '0;
        case (r.action)
            ACT_READ: begin
                rsp.found = 1'b1;
                if (int'(r.position) < lim)
                    rsp.bit_value = usage_map[r.position];
            end
            ACT_MARK_USED: begin
                rsp.found = 1'b1;
                mark_run(int'(r.position), int'(r.length), 1'b1);
            end
            ACT_MARK_FREE: begin
                rsp.found = 1'b1;
                mark_run(int'(r.position), int'(r.length), 1'b0);
            end
            ACT_SEARCH: begin
                for (int i = int'(r.position) + 1; i < lim; i++) begin
                    if (usage_map[i] == r.wanted_bit) begin
                        rsp.found           = 1'b1;
                        rsp.result_position = POS_W'(i);
                        break;
                    end
                end
            end
            ACT_FREE_RUN: begin
                if (r.length != '0 && int'(r.length) <= lim) begin
                    free_len = 0;
                    for (int i = 0; i < lim; i++) begin
                        free_len = usage_map[i] ? 0 : free_len + 1;
                        if (free_len == int'(r.length)) begin
                            rsp.found           = 1'b1;
                            rsp.result_position = POS_W'(i + 1 - int'(r.length));
                            break;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            usage_map   = '0;
            block_count = BLOCK_COUNT_RST;
            expected_rsp_q.delete();
        end else begin
            if (i_cfg_we)
                block_count = i_cfg_wdata;

            // Compare each response transfer with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_rsp_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("response %0d arrived with nothing outstanding: %p",
                                 rsp_index, i_out_data);
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (i_out_data.found !== exp_rsp.found ||
                        i_out_data.result_position !== exp_rsp.result_position ||
                        i_out_data.bit_value !== exp_rsp.bit_value) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"response %0d differs: expected found=%b pos=%0d bit=%b,",
                                      " got found=%b pos=%0d bit=%b"},
                                     rsp_index, exp_rsp.found, exp_rsp.result_position,
                                     exp_rsp.bit_value, i_out_data.found,
                                     i_out_data.result_position, i_out_data.bit_value);
                    end
                end
                rsp_index++;
            end

            // Predict the response of each request transfer
            if (i_in_valid && !i_in_stall)
                expected_rsp_q.push_back(apply_request(i_in_data));
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_rsp_q.size();
    end

endmodule

// File: test/block_bitmap_allocator_unit_tb.sv
// Testbench top for the block bitmap allocator: clock, reset, block count writes,
// directed and random requests, random response stalls and the final verdict.
// Depends on bba_pkg, block_bitmap_allocator_unit and block_bitmap_allocator_unit_checker.
`timescale 1ns / 1ps

module block_bitmap_allocator_unit_tb;
    import bba_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int PHASES       = 6;
    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int TAIL_CYCLES  = 40;

    // Action codes the block ignores
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_stall;
    t_req             in_data;
    logic             out_valid;
    logic             out_stall;
    t_rsp             out_data;
    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    int               active_count;
    bit               calm;

    block_bitmap_allocator_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    block_bitmap_allocator_unit_checker allocator_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Abort a run that hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic t_req make_req(logic [ACTION_W-1:0] action, int pos, int len, bit want);
        t_req r;
        r.action     = action;
        r.position   = POS_W'(pos);
        r.length     = LEN_W'(len);
        r.wanted_bit = want;
        return r;
    endfunction

    // Random request biased toward the active part of the map
    function automatic t_req random_request();
        t_req r;
        int   roll;
        int   last;
        last = (active_count > 0) ? active_count - 1 : 0;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            r.action = ACT_READ;
        else if (roll < 35)
            r.action = ACT_MARK_USED;
        else if (roll < 50)
            r.action = ACT_MARK_FREE;
        else if (roll < 70)
            r.action = ACT_SEARCH;
        else if (roll < 93)
            r.action = ACT_FREE_RUN;
        else
            r.action = ACTION_W'($urandom_range(ACT_READ, ACT_UNUSED_HI));
        roll = $urandom_range(0, 9);
        if (roll < 7)
            r.position = POS_W'($urandom_range(0, last));
        else if (roll == 7)
            r.position = '0;
        else if (roll == 8)
            r.position = POS_W'(last);
        else
            r.position = POS_W'($urandom);
        roll = $urandom_range(0, 9);
        if (roll < 6)
            r.length = LEN_W'($urandom_range(1, 32));
        else if (roll < 8)
            r.length = LEN_W'($urandom_range(33, 256));
        else if (roll == 8)
            r.length = $urandom_range(0, 1) ? LEN_W'(active_count) : '0;
        else
            r.length = LEN_W'($urandom);
        r.wanted_bit = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Present one request and hold it until the transfer
    task automatic send_request(input t_req r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and wait until every predicted response has arrived
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_block_count(input logic [CNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        active_count = (value > CNT_W'(NUM_BLOCKS_DEF)) ? NUM_BLOCKS_DEF : int'(value);
    endtask

    // Response side stalls
    initial begin
        int n;
        forever begin
            n = pick_gap();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (1 + pick_gap()) @(posedge clk);
        end
    end

    initial begin
        t_req             directed_q[$];
        logic [CNT_W-1:0] phase_count [PHASES];
        int               per_phase;

        calm         = 1'b0;
        active_count = NUM_BLOCKS_DEF;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: full map after reset
        directed_q = '{
            make_req(ACT_READ, 0, 0, 1'b0),
            make_req(ACT_READ, 1023, 2047, 1'b1),
            make_req(ACT_MARK_USED, 0, 1, 1'b0),
            make_req(ACT_READ, 0, 0, 1'b0),
            make_req(ACT_MARK_USED, 1020, 2047, 1'b1),
            make_req(ACT_MARK_USED, 5, 0, 1'b0),
            make_req(ACT_READ, 5, 0, 1'b0),
            make_req(ACT_SEARCH, 0, 0, 1'b1),
            make_req(ACT_SEARCH, 1022, 0, 1'b0),
            make_req(ACT_SEARCH, 1023, 0, 1'b1),
            make_req(ACT_FREE_RUN, 0, 0, 1'b0),
            make_req(ACT_FREE_RUN, 0, 1019, 1'b0),
            make_req(ACT_MARK_FREE, 1020, 4, 1'b0),
            make_req(ACT_FREE_RUN, 0, 1023, 1'b0),
            make_req(ACT_FREE_RUN, 1023, 1025, 1'b1),
            make_req(ACT_UNUSED_LO, 0, 0, 1'b0),
            make_req(ACT_UNUSED_HI, 1023, 2047, 1'b1),
            make_req(ACT_MARK_FREE, 0, 2047, 1'b0)
        };
        foreach (directed_q[i])
            send_request(directed_q[i]);
        drain();

        // Directed: zero block count disables everything
        write_block_count('0);
        directed_q = '{
            make_req(ACT_READ, 0, 0, 1'b0),
            make_req(ACT_MARK_USED, 0, 8, 1'b0),
            make_req(ACT_SEARCH, 0, 0, 1'b0),
            make_req(ACT_FREE_RUN, 0, 1, 1'b0)
        };
        foreach (directed_q[i])
            send_request(directed_q[i]);
        drain();

        // Directed: count above the map depth saturates
        write_block_count('1);
        directed_q = '{
            make_req(ACT_READ, 0, 0, 1'b0),
            make_req(ACT_FREE_RUN, 0, 1024, 1'b0),
            make_req(ACT_SEARCH, 1022, 0, 1'b0)
        };
        foreach (directed_q[i])
            send_request(directed_q[i]);
        drain();

        // Random phases over several block counts
        phase_count[0] = CNT_W'(NUM_BLOCKS_DEF);
        phase_count[1] = '1;
        phase_count[2] = CNT_W'($urandom_range(2, 1023));
        phase_count[3] = CNT_W'(1);
        phase_count[4] = CNT_W'(8);
        phase_count[5] = CNT_W'($urandom_range(0, 2047));
        per_phase = RANDOM_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++) begin
            write_block_count(phase_count[ph]);
            for (int n = 0; n < per_phase; n++) begin
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 2) == 0);
                send_request(random_request());
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
            drain();
        end
        calm = 1'b0;

        // Let any stray response show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
hdl/bba_pkg.sv
hdl/bba_word_unit.sv
hdl/block_bitmap_allocator_unit.sv
test/block_bitmap_allocator_unit_checker.sv
test/block_bitmap_allocator_unit_tb.sv
